@@ rtl/core/camellia128_block_cipher_defines.svh @@
// Assertion macros for the Camellia-128 RTL, used by the key schedule.
`ifndef CAMELLIA128_BLOCK_CIPHER_DEFINES_SVH
`define CAMELLIA128_BLOCK_CIPHER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define CAM128_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CAM128_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cam128_pkg.sv @@
// Package with the Camellia-128 types, constants, S-box and round functions.
`timescale 1ns / 1ps
package cam128_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 2'd1;

  // Number of Feistel rounds and position of the FL layers.
  localparam int unsigned NumRounds = 18;
  localparam int unsigned FlRoundA  = 5;
  localparam int unsigned FlRoundB  = 11;

  // Key schedule constants.
  localparam logic [63:0] SIGMA1 = 64'hA09E667F3BCC908B;
  localparam logic [63:0] SIGMA2 = 64'hB67AE8584CAA73B2;
  localparam logic [63:0] SIGMA3 = 64'hC6EF372FE94F82BE;
  localparam logic [63:0] SIGMA4 = 64'h54FF53A5F1D36F1C;

  // One block word in flight through the round chain.
  typedef struct packed {
    logic        dec;
    logic [63:0] d1;
    logic [63:0] d2;
  } cam_blk_t;

  // All subkeys for one block.
  typedef struct packed {
    logic [17:0][63:0] rk;
    logic [3:0][63:0]  ke;
    logic [3:0][63:0]  kw;
  } key_set_t;

  localparam logic [7:0] SBOX1 [256] = '{
    8'd112,8'd130,8'd44,8'd236,8'd179,8'd39,8'd192,8'd229,
    8'd228,8'd133,8'd87,8'd53,8'd234,8'd12,8'd174,8'd65,
    8'd35,8'd239,8'd107,8'd147,8'd69,8'd25,8'd165,8'd33,
    8'd237,8'd14,8'd79,8'd78,8'd29,8'd101,8'd146,8'd189,
    8'd134,8'd184,8'd175,8'd143,8'd124,8'd235,8'd31,8'd206,
    8'd62,8'd48,8'd220,8'd95,8'd94,8'd197,8'd11,8'd26,
    8'd166,8'd225,8'd57,8'd202,8'd213,8'd71,8'd93,8'd61,
    8'd217,8'd1,8'd90,8'd214,8'd81,8'd86,8'd108,8'd77,
    8'd139,8'd13,8'd154,8'd102,8'd251,8'd204,8'd176,8'd45,
    8'd116,8'd18,8'd43,8'd32,8'd240,8'd177,8'd132,8'd153,
    8'd223,8'd76,8'd203,8'd194,8'd52,8'd126,8'd118,8'd5,
    8'd109,8'd183,8'd169,8'd49,8'd209,8'd23,8'd4,8'd215,
    8'd20,8'd88,8'd58,8'd97,8'd222,8'd27,8'd17,8'd28,
    8'd50,8'd15,8'd156,8'd22,8'd83,8'd24,8'd242,8'd34,
    8'd254,8'd68,8'd207,8'd178,8'd195,8'd181,8'd122,8'd145,
    8'd36,8'd8,8'd232,8'd168,8'd96,8'd252,8'd105,8'd80,
    8'd170,8'd208,8'd160,8'd125,8'd161,8'd137,8'd98,8'd151,
    8'd84,8'd91,8'd30,8'd149,8'd224,8'd255,8'd100,8'd210,
    8'd16,8'd196,8'd0,8'd72,8'd163,8'd247,8'd117,8'd219,
    8'd138,8'd3,8'd230,8'd218,8'd9,8'd63,8'd221,8'd148,
    8'd135,8'd92,8'd131,8'd2,8'd205,8'd74,8'd144,8'd51,
    8'd115,8'd103,8'd246,8'd243,8'd157,8'd127,8'd191,8'd226,
    8'd82,8'd155,8'd216,8'd38,8'd200,8'd55,8'd198,8'd59,
    8'd129,8'd150,8'd111,8'd75,8'd19,8'd190,8'd99,8'd46,
    8'd233,8'd121,8'd167,8'd140,8'd159,8'd110,8'd188,8'd142,
    8'd41,8'd245,8'd249,8'd182,8'd47,8'd253,8'd180,8'd89,
    8'd120,8'd152,8'd6,8'd106,8'd231,8'd70,8'd113,8'd186,
    8'd212,8'd37,8'd171,8'd66,8'd136,8'd162,8'd141,8'd250,
    8'd114,8'd7,8'd185,8'd85,8'd248,8'd238,8'd172,8'd10,
    8'd54,8'd73,8'd42,8'd104,8'd60,8'd56,8'd241,8'd164,
    8'd64,8'd40,8'd211,8'd123,8'd187,8'd201,8'd67,8'd193,
    8'd21,8'd227,8'd173,8'd244,8'd119,8'd199,8'd128,8'd158
  };

  function automatic logic [7:0] rotl1_8(input logic [7:0] v);
    return {v[6:0], v[7]};
  endfunction

  function automatic logic [7:0] rotl7_8(input logic [7:0] v);
    return {v[0], v[7:1]};
  endfunction

  // The F function: key addition, S-box layer and P byte mix.
  function automatic logic [63:0] ffun(input logic [63:0] x_in, input logic [63:0] k);
    logic [63:0] x;
    logic [7:0]  t [8];
    logic [7:0]  y [8];
    x = x_in ^ k;
    t[0] = SBOX1[x[63:56]];
    t[1] = rotl1_8(SBOX1[x[55:48]]);
    t[2] = rotl7_8(SBOX1[x[47:40]]);
    t[3] = SBOX1[rotl1_8(x[39:32])];
    t[4] = rotl1_8(SBOX1[x[31:24]]);
    t[5] = rotl7_8(SBOX1[x[23:16]]);
    t[6] = SBOX1[rotl1_8(x[15:8])];
    t[7] = SBOX1[x[7:0]];
    y[0] = t[0] ^ t[2] ^ t[3] ^ t[5] ^ t[6] ^ t[7];
    y[1] = t[0] ^ t[1] ^ t[3] ^ t[4] ^ t[6] ^ t[7];
    y[2] = t[0] ^ t[1] ^ t[2] ^ t[4] ^ t[5] ^ t[7];
    y[3] = t[1] ^ t[2] ^ t[3] ^ t[4] ^ t[5] ^ t[6];
    y[4] = t[0] ^ t[1] ^ t[5] ^ t[6] ^ t[7];
    y[5] = t[1] ^ t[2] ^ t[4] ^ t[6] ^ t[7];
    y[6] = t[2] ^ t[3] ^ t[4] ^ t[5] ^ t[7];
    y[7] = t[0] ^ t[3] ^ t[4] ^ t[5] ^ t[6];
    return {y[0], y[1], y[2], y[3], y[4], y[5], y[6], y[7]};
  endfunction

  function automatic logic [63:0] fl_fwd(input logic [63:0] x, input logic [63:0] k);
    logic [31:0] xl;
    logic [31:0] xr;
    logic [31:0] a;
    xl = x[63:32];
    xr = x[31:0];
    a  = xl & k[63:32];
    xr = xr ^ {a[30:0], a[31]};
    xl = xl ^ (xr | k[31:0]);
    return {xl, xr};
  endfunction

  function automatic logic [63:0] fl_back(input logic [63:0] y, input logic [63:0] k);
    logic [31:0] yl;
    logic [31:0] yr;
    logic [31:0] a;
    yl = y[63:32];
    yr = y[31:0];
    yl = yl ^ (yr | k[31:0]);
    a  = yl & k[63:32];
    yr = yr ^ {a[30:0], a[31]};
    return {yl, yr};
  endfunction

  // Left rotation of a 128-bit value by a constant amount between 1 and 127.
  function automatic logic [127:0] rotl128(input logic [127:0] v, input int unsigned n);
    return (v << n) | (v >> (128 - n));
  endfunction

endpackage

@@ rtl/core/cam128_round_cell.sv @@
// One Feistel round cell of the Camellia-128 chain, with the FL layer where it applies.
`timescale 1ns / 1ps
module cam128_round_cell
  import cam128_pkg::*;
#(
  parameter int unsigned ROUND = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  key_set_t keys,
  input  logic     in_valid,
  input  cam_blk_t in_blk,
  output logic     out_valid,
  output cam_blk_t out_blk
);

  logic     valid_r;
  logic     valid_nxt;
  cam_blk_t blk_r;
  cam_blk_t blk_nxt;
  logic [63:0] rkey;
  cam_blk_t rnd;

  // Decryption walks the round keys from the far end.
  assign rkey = in_blk.dec ? keys.rk[NumRounds-1-ROUND] : keys.rk[ROUND];

  // Feistel round: the even rounds update the right half, the odd ones the left.
  always_comb begin
    rnd = in_blk;
    if ((ROUND % 2) == 0) begin
      rnd.d2 = in_blk.d2 ^ ffun(in_blk.d1, rkey);
    end else begin
      rnd.d1 = in_blk.d1 ^ ffun(in_blk.d2, rkey);
    end
  end

  // FL and FL-inverse after the sixth and twelfth rounds.
  always_comb begin
    blk_nxt = rnd;
    if (ROUND == FlRoundA) begin
      blk_nxt.d1 = fl_fwd(rnd.d1, rnd.dec ? keys.ke[3] : keys.ke[0]);
      blk_nxt.d2 = fl_back(rnd.d2, rnd.dec ? keys.ke[2] : keys.ke[1]);
    end else if (ROUND == FlRoundB) begin
      blk_nxt.d1 = fl_fwd(rnd.d1, rnd.dec ? keys.ke[1] : keys.ke[2]);
      blk_nxt.d2 = fl_back(rnd.d2, rnd.dec ? keys.ke[0] : keys.ke[3]);
    end
  end

  assign valid_nxt = in_valid;

  // Valid flag is control state; the data word needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

  assign out_valid = valid_r;
  assign out_blk   = blk_r;

endmodule

@@ rtl/core/cam128_key_sched.sv @@
// Key registers, KA derivation sequencer and subkey wiring for Camellia-128.
`timescale 1ns / 1ps
`include "camellia128_block_cipher_defines.svh"
module cam128_key_sched
  import cam128_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data,
  output logic               busy,
  output key_set_t           keys
);

  logic [63:0]  kh_r;
  logic [63:0]  kh_nxt;
  logic [63:0]  kl_r;
  logic [63:0]  kl_nxt;
  logic [63:0]  d1_r;
  logic [63:0]  d1_nxt;
  logic [63:0]  d2_r;
  logic [63:0]  d2_nxt;
  logic [1:0]   step_r;
  logic [1:0]   step_nxt;
  logic         busy_r;
  logic         busy_nxt;
  logic         load;
  logic [63:0]  d1x;
  logic [127:0] kl;
  logic [127:0] ka;
  logic [127:0] l15;
  logic [127:0] a15;
  logic [127:0] a30;
  logic [127:0] l45;
  logic [127:0] a45;
  logic [127:0] l60;
  logic [127:0] a60;
  logic [127:0] l77;
  logic [127:0] l94;
  logic [127:0] a94;
  logic [127:0] l111;
  logic [127:0] a111;

  // Key register writes; an index beyond the list changes nothing.
  always_comb begin
    kh_nxt = kh_r;
    kl_nxt = kl_r;
    load   = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_HIGH: begin
          kh_nxt = cfg_data;
          load   = 1'b1;
        end
        CFG_KEY_LOW: begin
          kl_nxt = cfg_data;
          load   = 1'b1;
        end
        default: load = 1'b0;
      endcase
    end
  end

  // KA derivation: four F steps, one per cycle, sharing the halves d1 and d2.
  assign d1x = d1_r ^ kh_r;

  always_comb begin
    d1_nxt   = d1_r;
    d2_nxt   = d2_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (load) begin
      d1_nxt   = kh_nxt;
      d2_nxt   = kl_nxt;
      step_nxt = 2'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      step_nxt = step_r + 2'd1;
      case (step_r)
        2'd0: d2_nxt = d2_r ^ ffun(d1_r, SIGMA1);
        2'd1: d1_nxt = d1_r ^ ffun(d2_r, SIGMA2);
        2'd2: begin
          d1_nxt = d1x;
          d2_nxt = d2_r ^ kl_r ^ ffun(d1x, SIGMA3);
        end
        2'd3: begin
          d1_nxt   = d1_r ^ ffun(d2_r, SIGMA4);
          busy_nxt = 1'b0;
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  // After reset the key is zero and its KA is derived before any word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kh_r   <= '0;
      kl_r   <= '0;
      d1_r   <= '0;
      d2_r   <= '0;
      step_r <= 2'd0;
      busy_r <= 1'b1;
    end else begin
      kh_r   <= kh_nxt;
      kl_r   <= kl_nxt;
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
      step_r <= step_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;

  // Subkeys are fixed rotations of KL and KA.
  assign kl   = {kh_r, kl_r};
  assign ka   = {d1_r, d2_r};
  assign l15  = rotl128(kl, 15);
  assign a15  = rotl128(ka, 15);
  assign a30  = rotl128(ka, 30);
  assign l45  = rotl128(kl, 45);
  assign a45  = rotl128(ka, 45);
  assign l60  = rotl128(kl, 60);
  assign a60  = rotl128(ka, 60);
  assign l77  = rotl128(kl, 77);
  assign l94  = rotl128(kl, 94);
  assign a94  = rotl128(ka, 94);
  assign l111 = rotl128(kl, 111);
  assign a111 = rotl128(ka, 111);

  always_comb begin
    keys.kw[0]  = kh_r;
    keys.kw[1]  = kl_r;
    keys.kw[2]  = a111[127:64];
    keys.kw[3]  = a111[63:0];
    keys.rk[0]  = d1_r;
    keys.rk[1]  = d2_r;
    keys.rk[2]  = l15[127:64];
    keys.rk[3]  = l15[63:0];
    keys.rk[4]  = a15[127:64];
    keys.rk[5]  = a15[63:0];
    keys.ke[0]  = a30[127:64];
    keys.ke[1]  = a30[63:0];
    keys.rk[6]  = l45[127:64];
    keys.rk[7]  = l45[63:0];
    keys.rk[8]  = a45[127:64];
    keys.rk[9]  = l60[63:0];
    keys.rk[10] = a60[127:64];
    keys.rk[11] = a60[63:0];
    keys.ke[2]  = l77[127:64];
    keys.ke[3]  = l77[63:0];
    keys.rk[12] = l94[127:64];
    keys.rk[13] = l94[63:0];
    keys.rk[14] = a94[127:64];
    keys.rk[15] = a94[63:0];
    keys.rk[16] = l111[127:64];
    keys.rk[17] = l111[63:0];
  end

  // A key write always starts a derivation.
  `CAM128_ASSERT_NEXT(a_write_starts, load, busy_r && step_r == 2'd0, "key write did not start KA derivation")
  // The last derivation step ends the busy period unless a new write arrives.
  `CAM128_ASSERT_NEXT(a_last_step_ends, busy_r && step_r == 2'd3 && !cfg_we, !busy_r, "KA derivation overran")
  // Without a write, an idle schedule stays idle and KA stays put.
  `CAM128_ASSERT_NEXT(a_idle_holds, !busy_r && !cfg_we, !busy_r && $stable(ka), "KA changed without a key write")

endmodule

@@ rtl/core/camellia128_block_cipher.sv @@
// Camellia-128 top level: whitening, a chain of 18 round cells, output whitening.
// The result and its strobe are registered after the input whitening register and the 18 round cells.
// Throughput: one word per cycle while busy is low, the 18 round cells each holding one word in flight.
// A key write keeps busy high while the KA half is derived, one F step a cycle.
// Reset (rst_n low, synchronous) zeroes the key, empties the chain and derives the zero-key KA.
`timescale 1ns / 1ps
module camellia128_block_cipher
  import cam128_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [63:0]        in_block_high,
  input  logic [63:0]        in_block_low,
  input  logic               in_func,
  output logic               out_strobe,
  output logic [63:0]        out_result_high,
  output logic [63:0]        out_result_low,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data
);

  key_set_t keys;
  logic     accept;
  logic     s0_valid_r;
  logic     s0_valid_nxt;
  cam_blk_t s0_r;
  cam_blk_t s0_nxt;
  logic     cv [NumRounds+1];
  cam_blk_t cb [NumRounds+1];
  logic        out_strobe_r;
  logic        out_strobe_nxt;
  logic [63:0] res_hi_r;
  logic [63:0] res_hi_nxt;
  logic [63:0] res_lo_r;
  logic [63:0] res_lo_nxt;
  cam_blk_t    last;

  cam128_key_sched u_key_sched (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .keys      (keys)
  );

  // Input whitening into the first stage.
  assign accept       = start && !busy;
  assign s0_valid_nxt = accept;

  always_comb begin
    s0_nxt.dec = in_func;
    s0_nxt.d1  = in_block_high ^ (in_func ? keys.kw[2] : keys.kw[0]);
    s0_nxt.d2  = in_block_low  ^ (in_func ? keys.kw[3] : keys.kw[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
  end

  assign cv[0] = s0_valid_r;
  assign cb[0] = s0_r;

  // Chain of round cells, each handing its word to the next every cycle.
  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    cam128_round_cell #(
      .ROUND (r)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .keys      (keys),
      .in_valid  (cv[r]),
      .in_blk    (cb[r]),
      .out_valid (cv[r+1]),
      .out_blk   (cb[r+1])
    );
  end

  // Output whitening with the halves swapped.
  assign last           = cb[NumRounds];
  assign out_strobe_nxt = cv[NumRounds];
  assign res_hi_nxt     = last.d2 ^ (last.dec ? keys.kw[0] : keys.kw[2]);
  assign res_lo_nxt     = last.d1 ^ (last.dec ? keys.kw[1] : keys.kw[3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_hi_r <= res_hi_nxt;
    res_lo_r <= res_lo_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_result_high = res_hi_r;
  assign out_result_low  = res_lo_r;

endmodule
